@@ rtl/core/adtsrtp_pkg.sv @@
// shared types and constants of the adts to rtp aac packetizer
// used by the front, queue, back and top level modules; no dependencies

package adtsrtp_pkg;

    // command kinds passed from the front to the back
    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_ERROR   = 2'd1,
        K_AUHDR   = 2'd2
    } t_kind;

    // front state: collecting header or passing payload
    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    // one queued command
    typedef struct packed {
        t_kind        kind;
        logic [7:0]   data;
        logic         last;
        logic [15:0]  seq;
        logic [31:0]  rtp_time;
        logic [1:0]   profile;
        logic [3:0]   rate;
        logic [2:0]   chan;
        logic [12:0]  flen;
    } t_cmd;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

    // one result on the master side
    typedef struct packed {
        logic [79:0] tdata;
        logic        tlast;
        logic        tuser;
    } t_result;

    localparam logic [15:0] TS_STEP_RESET = 16'd1025;
    localparam logic [7:0]  SYNC_HI       = 8'hFF;
    localparam logic [3:0]  SYNC_LO       = 4'hF;
    localparam logic [12:0] ADTS_HDR_LEN  = 13'd7;
    localparam logic [12:0] MIN_FRAME_LEN = 13'd8;
    localparam logic [7:0]  AU_HDR_B0     = 8'h00;
    localparam logic [7:0]  AU_HDR_B1     = 8'h10;
    localparam logic [2:0]  HDR_LAST_IDX  = 3'd6;
    localparam logic [1:0]  AU_LAST_SUB   = 2'd3;

endpackage

@@ rtl/core/adtsrtp_front.sv @@
// front: accepts stream bytes, gathers the adts header and classifies items
// depends on adtsrtp_pkg; pushes commands into adtsrtp_fifo

module adtsrtp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic [15:0]          i_ts_step,
    input  adtsrtp_pkg::t_qstat  i_qstat,
    output logic                 o_push,
    output adtsrtp_pkg::t_cmd    o_cmd
);
    import adtsrtp_pkg::*;

    t_phase       r_phase, n_phase;
    logic [2:0]   r_hcount, n_hcount;
    logic [47:0]  r_hbytes, n_hbytes;
    logic [12:0]  r_left, n_left;
    logic [15:0]  r_seq, n_seq;
    logic [31:0]  r_time, n_time;

    logic         w_acc;
    logic [7:0]   w_b0, w_b1, w_b2, w_b3, w_b4, w_b5;
    logic [12:0]  w_len;
    logic         w_bad;
    logic         w_last;

    // header bytes, first received byte highest
    assign w_b0 = r_hbytes[47:40];
    assign w_b1 = r_hbytes[39:32];
    assign w_b2 = r_hbytes[31:24];
    assign w_b3 = r_hbytes[23:16];
    assign w_b4 = r_hbytes[15:8];
    assign w_b5 = r_hbytes[7:0];
    assign w_len = {w_b3[1:0], w_b4, w_b5[7:5]};
    assign w_bad = (w_b0 != SYNC_HI) || (w_b1[7:4] != SYNC_LO) || (w_len < MIN_FRAME_LEN);
    assign w_last = (r_left <= 13'd1);

    // header bytes one to six never push, so they pass even with a full queue
    assign o_ready = !i_qstat.full || ((r_phase == PH_HEADER) && (r_hcount != HDR_LAST_IDX));
    assign w_acc = i_valid && o_ready;

    // command fields common to every result, then push and next-state decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.seq      = r_seq;
        o_cmd.rtp_time = r_time;
        o_cmd.profile  = w_b2[7:6];
        o_cmd.rate     = w_b2[5:2];
        o_cmd.chan     = {w_b2[0], w_b3[7:6]};
        o_cmd.flen     = w_len;
        o_push         = 1'b0;
        n_phase        = r_phase;
        n_hcount       = r_hcount;
        n_hbytes       = r_hbytes;
        n_left         = r_left;
        n_seq          = r_seq;
        n_time         = r_time;
        if (w_acc) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_PAYLOAD;
                    o_cmd.data = i_byte;
                    o_cmd.last = w_last;
                    if (w_last) begin
                        n_phase  = PH_HEADER;
                        n_hcount = '0;
                        n_left   = '0;
                        n_seq    = r_seq + 16'd1;
                        n_time   = r_time + {16'd0, i_ts_step};
                    end else begin
                        n_left = r_left - 13'd1;
                    end
                end
                default: begin
                    if (r_hcount != HDR_LAST_IDX) begin
                        n_hbytes = {r_hbytes[39:0], i_byte};
                        n_hcount = r_hcount + 3'd1;
                    end else begin
                        // seventh byte: header complete, byte itself is dropped
                        n_hcount = '0;
                        o_push   = 1'b1;
                        if (w_bad) begin
                            o_cmd.kind = K_ERROR;
                        end else begin
                            o_cmd.kind = K_AUHDR;
                            n_left     = w_len - ADTS_HDR_LEN;
                            n_phase    = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    // control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcount <= '0;
            r_left   <= '0;
            r_seq    <= '0;
            r_time   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_left   <= n_left;
            r_seq    <= n_seq;
            r_time   <= n_time;
        end
    end

    // header shift register, no reset
    always_ff @(posedge i_clk) begin
        r_hbytes <= n_hbytes;
    end

`ifndef ASSERT_OFF
    // header count never runs past the seventh byte
    a_hcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcount <= HDR_LAST_IDX)
        else $error("header count out of range");

    // a push only happens when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_qstat.full)
        else $error("push into full queue");
`endif

endmodule

@@ rtl/core/adtsrtp_fifo.sv @@
// short command queue between front and back
// depends on adtsrtp_pkg for the command and status types

module adtsrtp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  adtsrtp_pkg::t_cmd    i_cmd,
    input  logic                 i_pop,
    output adtsrtp_pkg::t_cmd    o_head,
    output adtsrtp_pkg::t_qstat  o_qstat
);
    import adtsrtp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd           r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_qstat.full  = (r_count == FULL_CNT);
    assign o_qstat.valid = (r_count != '0);
    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && o_qstat.valid;
    assign o_head = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    // fill count stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/adtsrtp_back.sv @@
// back: expands queued commands into results and holds the output register
// depends on adtsrtp_pkg; pops commands from adtsrtp_fifo

module adtsrtp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adtsrtp_pkg::t_qstat  i_qstat,
    input  adtsrtp_pkg::t_cmd    i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output adtsrtp_pkg::t_result o_res
);
    import adtsrtp_pkg::*;

    logic         r_ov;
    logic [1:0]   r_sub;
    t_result      r_res, n_res;
    logic         w_load;
    logic         w_is_au;
    logic [12:0]  w_plen;
    logic [7:0]   w_byte;

    assign w_load  = i_qstat.valid && (!r_ov || i_ready);
    assign w_is_au = (i_head.kind == K_AUHDR);
    assign o_pop   = w_load && (!w_is_au || (r_sub == AU_LAST_SUB));
    assign w_plen  = i_head.flen - ADTS_HDR_LEN;

    // byte of the current result
    always_comb begin
        case (i_head.kind)
            K_AUHDR: begin
                case (r_sub)
                    2'd0:    w_byte = AU_HDR_B0;
                    2'd1:    w_byte = AU_HDR_B1;
                    2'd2:    w_byte = w_plen[12:5];
                    default: w_byte = {w_plen[4:0], 3'b000};
                endcase
            end
            K_PAYLOAD: w_byte = i_head.data;
            default:   w_byte = 8'h00;
        endcase
    end

    // result packing: byte, seq, time, profile, rate, channels, length
    always_comb begin
        n_res       = '0;
        n_res.tdata = {2'b00, i_head.flen, i_head.chan, i_head.rate, i_head.profile,
                       i_head.rtp_time, i_head.seq, w_byte};
        n_res.tlast = (i_head.kind == K_PAYLOAD) && i_head.last;
        n_res.tuser = (i_head.kind == K_ERROR);
    end

    // output valid and au header sub-step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_sub <= '0;
        end else begin
            if (w_load) begin
                r_ov  <= 1'b1;
                r_sub <= (w_is_au && (r_sub != AU_LAST_SUB)) ? r_sub + 2'd1 : 2'd0;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

`ifndef ASSERT_OFF
    // a started au header keeps its command at the head of the queue
    a_sub_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> (i_qstat.valid && w_is_au))
        else $error("au header sequence lost its command");

    // a result never marks both end of packet and error
    a_last_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_res.tlast && r_res.tuser))
        else $error("last and error set together");
`endif

endmodule

@@ rtl/core/adts_to_rtp_aac_packetizer.sv @@
// top level of the adts to rfc 3640 aac packetizer: apb register, front, queue, back
// depends on adtsrtp_pkg, adtsrtp_front, adtsrtp_fifo and adtsrtp_back
//
// channel   | direction | handshake             | contents
// s stream  | in        | tvalid/tready         | one adts byte
// m stream  | out       | tvalid/tready         | au header or payload byte, tlast, tuser error
// apb       | in        | psel/penable/pwrite   | timestamp_step at address 0
//
// payload bytes pass at one per cycle while the queue has room; the back stage turns the
// seventh header byte into four results (one error result if bad), bytes one to six give none
// the queue of QUEUE_DEPTH commands lets the front keep taking bytes during that burst
// synchronous active-low reset clears counters, queue and output valid; no clearing pass
// a stalled output holds its result while the front keeps filling the queue

module adts_to_rtp_aac_packetizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,    // [7:0] in_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] out_byte, [23:8] seq_number, [55:24] rtp_time, [57:56] profile_code,
    // [61:58] rate_index, [64:62] channel_code, [77:65] frame_bytes, [79:78] zero
    output logic [79:0]  o_m_tdata,
    output logic         o_m_tlast,    // last_in_packet
    output logic         o_m_tuser,    // [0] header_error
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);
    import adtsrtp_pkg::*;

    logic [15:0]  r_ts_step;
    logic         w_push, w_pop;
    t_cmd         w_cmd, w_head;
    t_qstat       w_qstat;
    t_result      w_res;

    // configuration register
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == 1'b0) ? {16'd0, r_ts_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_step <= TS_STEP_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && (i_paddr[2] == 1'b0)) begin
            r_ts_step <= i_pwdata[15:0];
        end
    end

    // header collection and classification
    adtsrtp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_ts_step (r_ts_step),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_cmd     (w_cmd)
    );

    // command queue
    adtsrtp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // result expansion and output register
    adtsrtp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res)
    );

    assign o_m_tdata = w_res.tdata;
    assign o_m_tlast = w_res.tlast;
    assign o_m_tuser = w_res.tuser;

endmodule

@@ test/adtsrtp_checker.sv @@
`timescale 1ns / 1ps
// checker for the adts to rtp aac packetizer: watches the stream and apb channels,
// predicts every output transaction and compares it field by field; uses adtsrtp_pkg

module adtsrtp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,    // [7:0] in_byte
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] out_byte, [23:8] seq_number, [55:24] rtp_time, [57:56] profile_code,
    // [61:58] rate_index, [64:62] channel_code, [77:65] frame_bytes, [79:78] zero
    input  logic [79:0]  i_m_tdata,
    input  logic         i_m_tlast,    // last_in_packet
    input  logic         i_m_tuser,    // [0] header_error
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic [31:0]  i_prdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);
    import adtsrtp_pkg::*;

    localparam int REG_TS_STEP = 0;
    localparam int PRINT_LIMIT = 50;

    // one predicted output byte with its packet context
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        err;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [1:0]  profile;
        logic [3:0]  rate;
        logic [2:0]  chan;
        logic [12:0] flen;
    } t_rtp_byte;

    t_rtp_byte   rtp_bytes_due[$];

    // packetizer state as predicted
    t_phase      phase;
    logic [2:0]  hdr_cnt;
    logic [47:0] hdr;
    logic [12:0] left;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [15:0] step;
    int          fails;
    int          checked;

    // report one field that differs
    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= PRINT_LIMIT)
                $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            else if (fails == PRINT_LIMIT + 1)
                $display("%0t ns: further mismatches counted but not shown", $time);
        end
    endtask

    // queue one output byte tagged with the current header and counters
    task automatic queue_rtp_byte(input logic [7:0] data, input logic last, input logic err);
        t_rtp_byte r;
        r.data    = data;
        r.last    = last;
        r.err     = err;
        r.seq     = seq;
        r.stamp   = stamp;
        r.profile = hdr[31:30];
        r.rate    = hdr[29:26];
        r.chan    = {hdr[24], hdr[23:22]};
        r.flen    = {hdr[17:16], hdr[15:8], hdr[7:5]};
        rtp_bytes_due.push_back(r);
    endtask

    // advance the packetizer by one accepted stream byte
    task automatic packetize_byte(input logic [7:0] b);
        logic [12:0] flen;
        logic [12:0] plen;
        logic        sync_ok;
        if (phase == PH_PAYLOAD) begin
            queue_rtp_byte(b, left <= 13'd1, 1'b0);
            if (left <= 13'd1) begin
                phase   = PH_HEADER;
                hdr_cnt = 3'd0;
                left    = 13'd0;
                seq     = seq + 16'd1;
                stamp   = stamp + {16'h0, step};
            end else begin
                left = left - 13'd1;
            end
        end else if (hdr_cnt < HDR_LAST_IDX) begin
            hdr[(5 - int'(hdr_cnt)) * 8 +: 8] = b;
            hdr_cnt = hdr_cnt + 3'd1;
        end else begin
            // seventh header byte: error or au header
            hdr_cnt = 3'd0;
            flen    = {hdr[17:16], hdr[15:8], hdr[7:5]};
            sync_ok = (hdr[47:40] == SYNC_HI) && (hdr[39:36] == SYNC_LO);
            if (!sync_ok || flen < MIN_FRAME_LEN) begin
                queue_rtp_byte(8'h00, 1'b0, 1'b1);
            end else begin
                plen = flen - ADTS_HDR_LEN;
                queue_rtp_byte(AU_HDR_B0, 1'b0, 1'b0);
                queue_rtp_byte(AU_HDR_B1, 1'b0, 1'b0);
                queue_rtp_byte(plen[12:5], 1'b0, 1'b0);
                queue_rtp_byte({plen[4:0], 3'b000}, 1'b0, 1'b0);
                left  = plen;
                phase = PH_PAYLOAD;
            end
        end
    endtask

    // compare one output transaction with the oldest prediction
    task automatic check_rtp_byte();
        t_rtp_byte r;
        checked++;
        if (rtp_bytes_due.size() == 0) begin
            fails++;
            $display("%0t ns: output transaction expected none actual 0x%0h",
                     $time, i_m_tdata[7:0]);
        end else begin
            r = rtp_bytes_due.pop_front();
            note_field("out_byte", 32'(r.data), 32'(i_m_tdata[7:0]));
            note_field("seq_number", 32'(r.seq), 32'(i_m_tdata[23:8]));
            note_field("rtp_time", r.stamp, i_m_tdata[55:24]);
            note_field("profile_code", 32'(r.profile), 32'(i_m_tdata[57:56]));
            note_field("rate_index", 32'(r.rate), 32'(i_m_tdata[61:58]));
            note_field("channel_code", 32'(r.chan), 32'(i_m_tdata[64:62]));
            note_field("frame_bytes", 32'(r.flen), 32'(i_m_tdata[77:65]));
            note_field("tdata pad", 32'd0, 32'(i_m_tdata[79:78]));
            note_field("last_in_packet", 32'(r.last), 32'(i_m_tlast));
            note_field("header_error", 32'(r.err), 32'(i_m_tuser));
        end
    endtask

    // per edge: outputs first, then register access, then the new input byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rtp_bytes_due.delete();
            phase   = PH_HEADER;
            hdr_cnt = 3'd0;
            hdr     = 48'h0;
            left    = 13'd0;
            seq     = 16'd0;
            stamp   = 32'd0;
            step    = TS_STEP_RESET;
            fails   = 0;
            checked = 0;
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_rtp_byte();
            if (i_psel && i_penable && i_pready && (int'(i_paddr >> 2) == REG_TS_STEP)) begin
                if (i_pwrite)
                    step = i_pwdata[15:0];
                else
                    note_field("timestamp_step read", 32'(step), 32'(i_prdata[15:0]));
            end
            if (i_s_tvalid && i_s_tready)
                packetize_byte(i_s_tdata);
        end
        o_fail_count <= fails;
        o_pending    <= rtp_bytes_due.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top for adts_to_rtp_aac_packetizer: clock, reset, stream and apb stimulus, verdict
// depends on adtsrtp_pkg, the packetizer rtl and adtsrtp_checker

module tb_top;
    import adtsrtp_pkg::*;

    localparam logic [2:0] ADDR_TS_STEP = 3'd0;
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;
    localparam int         PHASE_BYTES  = 30;
    localparam int         DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        m_tready = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;

    wire         s_tready;
    wire         m_tvalid;
    wire  [79:0] m_tdata;
    wire         m_tlast;
    wire         m_tuser;
    wire  [31:0] prdata;
    wire         pready;

    int          fail_count;
    int          pending;
    int          checked;

    bit          quiet;
    int          bytes_sent;
    int          good_frames;
    int          bad_headers;
    int          settings;
    int          sink_hold;
    int          sink_wait;

    always #5 clk = ~clk;

    adts_to_rtp_aac_packetizer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    adtsrtp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // output side: after each transaction a random stall, none while quiet
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid) begin
            sink_wait = quiet ? 0 : $urandom_range(0, 4);
            if (sink_wait != 0) begin
                m_tready  <= 1'b0;
                sink_hold <= sink_wait;
            end
        end
    end

    // one apb access: setup phase, then access phase until pready, then back to idle
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one stream transaction after a random gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    // adts header with the given fields, random spare bits, then the payload if valid
    task automatic send_frame(input logic [7:0] sync0, input logic [3:0] sync1,
                              input logic [1:0] prof, input logic [3:0] rate,
                              input logic [2:0] chan, input logic [12:0] flen);
        logic [7:0] hb [0:6];
        int         n;
        hb[0] = sync0;
        hb[1] = {sync1, 4'($urandom_range(0, 15))};
        hb[2] = {prof, rate, 1'($urandom_range(0, 1)), chan[2]};
        hb[3] = {chan[1:0], 4'($urandom_range(0, 15)), flen[12:11]};
        hb[4] = flen[10:3];
        hb[5] = {flen[2:0], 5'($urandom_range(0, 31))};
        hb[6] = 8'($urandom_range(0, 255));
        n = (sync0 == SYNC_HI && sync1 == SYNC_LO && flen >= MIN_FRAME_LEN) ?
            int'(flen - ADTS_HDR_LEN) : 0;
        if (n == 0)
            bad_headers++;
        else
            good_frames++;
        for (int k = 0; k < 7; k++)
            send_byte(hb[k]);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // hold the stream until every predicted output has arrived
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // new timestamp step between phases, read back
    task automatic set_step(input logic [31:0] value);
        settle();
        apb_access(1'b1, ADDR_TS_STEP, value);
        apb_access(1'b0, ADDR_TS_STEP, 32'h0);
        settings++;
    endtask

    // one random frame: mostly well formed, some broken headers and noise
    task automatic random_frame();
        int kind;
        kind  = $urandom_range(0, 9);
        quiet = ($urandom_range(0, 3) == 0);
        case (kind)
            0: begin
                send_frame(SYNC_HI, 4'($urandom_range(0, 14)), 2'($urandom_range(0, 3)),
                           4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                           13'($urandom_range(0, 8191)));
            end
            1: begin
                send_frame(SYNC_HI, SYNC_LO, 2'($urandom_range(0, 3)),
                           4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                           13'($urandom_range(0, 7)));
            end
            2: begin
                // noise that cannot start a valid header
                bad_headers++;
                send_byte(8'($urandom_range(0, 254)));
                repeat (6) send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                send_frame(SYNC_HI, SYNC_LO, 2'($urandom_range(0, 3)),
                           4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                           ($urandom_range(0, 15) == 0) ? 13'($urandom_range(8, 100)) :
                                                          13'($urandom_range(8, 40)));
            end
        endcase
    endtask

    initial begin
        int phase_start;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'h0;
        quiet    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the step, then directed frames
        apb_access(1'b0, ADDR_TS_STEP, 32'h0);
        send_frame(SYNC_HI, SYNC_LO, 2'd3, 4'd15, 3'd7, MIN_FRAME_LEN);
        send_frame(8'h00, 4'h0, 2'd0, 4'd0, 3'd0, 13'd0);
        send_frame(SYNC_HI, SYNC_LO, 2'd1, 4'd4, 3'd2, ADTS_HDR_LEN);

        // random phases, each under its own timestamp step
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_step(32'h0);
                1: set_step(32'h0000_FFFF);
                2: begin
                    set_step({16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535))});
                    apb_access(1'b1, ADDR_UNUSED, 32'($urandom));
                    apb_access(1'b0, ADDR_TS_STEP, 32'h0);
                    // one longer frame with no idling
                    quiet = 1'b1;
                    send_frame(SYNC_HI, SYNC_LO, 2'($urandom_range(0, 3)),
                               4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                               13'($urandom_range(40, 64)));
                end
                default: set_step(32'($urandom_range(0, 65535)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
        end

        settle();
        @(negedge clk);
        $display("run covered %0d stream bytes in %0d frames and %0d broken headers",
                 bytes_sent, good_frames, bad_headers);
        $display("%0d output transactions checked under %0d timestamp steps",
                 checked, settings + 1);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
